// File: sv/v3alu_pkg.sv
// ----------------------------------------------------------------------------
// v3alu_pkg: shared types and helpers for the 3D vector unit
// Word layouts of both channels, opcode names, fixed-point rounding and
// 32-bit saturation used by the vector unit and its normalize lanes.
// ----------------------------------------------------------------------------
package v3alu_pkg;

  localparam logic [3:0] FUNC_ADD       = 4'd0;
  localparam logic [3:0] FUNC_SUB       = 4'd1;
  localparam logic [3:0] FUNC_SCALE     = 4'd2;
  localparam logic [3:0] FUNC_DOT       = 4'd3;
  localparam logic [3:0] FUNC_CROSS     = 4'd4;
  localparam logic [3:0] FUNC_LENGTH    = 4'd5;
  localparam logic [3:0] FUNC_NORMALIZE = 4'd6;
  localparam logic [3:0] FUNC_ROTATE    = 4'd7;
  localparam logic [3:0] FUNC_ABS       = 4'd8;

  // square root pipeline: one stage per result bit plus the rounding stage
  localparam int ISQRT_LAT = 33;

  localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
  localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

  typedef struct packed {
    logic [3:0]         func;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] scale;
  } v3alu_in_t;

  typedef struct packed {
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic signed [31:0] r_scalar;
    logic               zero_length;
    logic               overflow;
  } v3alu_out_t;

  // latency of one normalize unit: squares, sum, root, dividend, divide, sign
  function automatic int norm_lat(input int fb);
    return fb + ISQRT_LAT + 5;
  endfunction

  // drop fb fraction bits, rounding half up
  function automatic logic signed [65:0] qround(input logic signed [65:0] v, input int fb);
    logic signed [65:0] half;
    half = 66'sd1 <<< (fb - 1);
    return (v + half) >>> fb;
  endfunction

  // returns {saturated, value}
  function automatic logic [32:0] sat32(input logic signed [65:0] v);
    logic [32:0] res;
    if (v > SAT_MAX) begin
      res = {1'b1, 32'h7fff_ffff};
    end else if (v < SAT_MIN) begin
      res = {1'b1, 32'h8000_0000};
    end else begin
      res = {1'b0, v[31:0]};
    end
    return res;
  endfunction

endpackage

// File: sv/v3alu_delay.sv
// ----------------------------------------------------------------------------
// v3alu_delay: fixed-length shift line
// Passes a word through DEPTH registers to line it up with a longer pipeline path.
// ----------------------------------------------------------------------------
module v3alu_delay import v3alu_pkg::*; #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] sr_r [DEPTH];

  always_ff @(posedge clk) begin
    sr_r[0] <= d_i;
    for (int i = 1; i < DEPTH; i++) begin
      sr_r[i] <= sr_r[i-1];
    end
  end

  assign q_o = sr_r[DEPTH-1];

endmodule

// File: sv/v3alu_isqrt.sv
// ----------------------------------------------------------------------------
// v3alu_isqrt: pipelined integer square root
// One result bit per stage, then round to nearest using the remainder.
// ----------------------------------------------------------------------------
module v3alu_isqrt import v3alu_pkg::*; (
  input  logic        clk,
  input  logic [63:0] n_i,
  output logic [32:0] root_o
);

  logic [63:0] x_r   [1:32];
  logic [63:0] res_r [1:32];
  logic [32:0] root_r;

  for (genvar k = 0; k < 32; k++) begin : g_stg
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] x_in;
    logic [63:0] res_in;
    logic [63:0] trial;

    if (k == 0) begin : g_first
      assign x_in   = n_i;
      assign res_in = '0;
    end else begin : g_next
      assign x_in   = x_r[k];
      assign res_in = res_r[k];
    end

    assign trial = res_in + BIT;

    always_ff @(posedge clk) begin
      if (x_in >= trial) begin
        x_r[k+1]   <= x_in - trial;
        res_r[k+1] <= (res_in >> 1) + BIT;
      end else begin
        x_r[k+1]   <= x_in;
        res_r[k+1] <= res_in >> 1;
      end
    end
  end

  // remainder above the root means the value sits past the half point
  always_ff @(posedge clk) begin
    root_r <= res_r[32][32:0] + 33'(x_r[32] > res_r[32]);
  end

  assign root_o = root_r;

endmodule

// File: sv/v3alu_div.sv
// ----------------------------------------------------------------------------
// v3alu_div: pipelined restoring divider lane
// One quotient bit per stage; the quotient is known to fit in QW bits.
// ----------------------------------------------------------------------------
module v3alu_div import v3alu_pkg::*; #(
  parameter int QW = 17
) (
  input  logic            clk,
  input  logic [QW+33:0]  num_i,
  input  logic [32:0]     den_i,
  output logic [QW-1:0]   quo_o
);

  localparam int DW = QW + 34;

  logic [DW-1:0] rem_r [1:QW-1];
  logic [32:0]   den_r [1:QW-1];
  logic [QW-1:0] quo_r [1:QW];

  for (genvar k = 0; k < QW; k++) begin : g_stg
    logic [DW-1:0] rem_in;
    logic [32:0]   den_in;
    logic [QW-1:0] quo_in;
    logic [DW-1:0] sh;
    logic          take;

    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k];
      assign den_in = den_r[k];
      assign quo_in = quo_r[k];
    end

    assign sh   = DW'(den_in) << (QW - 1 - k);
    assign take = rem_in >= sh;

    always_ff @(posedge clk) begin
      quo_r[k+1] <= {quo_in[QW-2:0], take};
    end

    if (k < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_r[k+1] <= take ? rem_in - sh : rem_in;
        den_r[k+1] <= den_in;
      end
    end
  end

  assign quo_o = quo_r[QW];

endmodule

// File: sv/v3alu_norm.sv
// ----------------------------------------------------------------------------
// v3alu_norm: pipelined vector normalize
// Length by square root of the sum of squares, then three divider lanes
// give each component over the rounded length, rounded half away from zero.
// ----------------------------------------------------------------------------
module v3alu_norm import v3alu_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic signed [31:0]       v_i    [3],
  output logic signed [FRAC_BITS+1:0] r_o [3],
  output logic                     zero_o,
  output logic [32:0]              len_o
);

  localparam int QW = FRAC_BITS + 1;
  localparam int DW = QW + 34;
  localparam int RW = QW + 1;

  logic signed [63:0] sq_s  [3];
  logic [63:0]        sq_r  [3];
  logic [63:0]        sum_r;
  logic [32:0]        root;
  logic [95:0]        mag_pk;
  logic [95:0]        mag_d;
  logic [2:0]         sgn_d;
  logic [DW-1:0]      num_r [3];
  logic [32:0]        den_r;
  logic [QW-1:0]      quo   [3];
  logic [32:0]        len_d;
  logic signed [RW-1:0] r_r [3];
  logic [32:0]        len_r;

  for (genvar i = 0; i < 3; i++) begin : g_sq
    assign sq_s[i] = v_i[i] * v_i[i];
    assign mag_pk[32*i +: 32] = v_i[i][31] ? 32'(-v_i[i]) : 32'(v_i[i]);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq_r[i] <= sq_s[i];
    end
    sum_r <= sq_r[0] + sq_r[1] + sq_r[2];
  end

  v3alu_isqrt u_isqrt (
    .clk    (clk),
    .n_i    (sum_r),
    .root_o (root)
  );

  // hold magnitudes until the root is out, signs until the quotients are
  v3alu_delay #(.WIDTH(96), .DEPTH(ISQRT_LAT + 2)) u_mag_dly (
    .clk (clk),
    .d_i (mag_pk),
    .q_o (mag_d)
  );

  v3alu_delay #(.WIDTH(3), .DEPTH(ISQRT_LAT + 3 + QW)) u_sgn_dly (
    .clk (clk),
    .d_i ({v_i[2][31], v_i[1][31], v_i[0][31]}),
    .q_o (sgn_d)
  );

  v3alu_delay #(.WIDTH(33), .DEPTH(QW + 1)) u_len_dly (
    .clk (clk),
    .d_i (root),
    .q_o (len_d)
  );

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      num_r[i] <= (DW'(mag_d[32*i +: 32]) << FRAC_BITS) + DW'(root >> 1);
    end
    den_r <= root;
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    v3alu_div #(.QW(QW)) u_div (
      .clk   (clk),
      .num_i (num_r[i]),
      .den_i (den_r),
      .quo_o (quo[i])
    );
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (len_d == '0) begin
        r_r[i] <= '0;
      end else if (sgn_d[i]) begin
        r_r[i] <= -RW'(quo[i]);
      end else begin
        r_r[i] <= RW'(quo[i]);
      end
    end
    len_r <= len_d;
  end

  assign r_o    = r_r;
  assign len_o  = len_r;
  assign zero_o = (len_r == '0);

endmodule

// File: sv/vector3_alu.sv
// ----------------------------------------------------------------------------
// vector3_alu: pipelined 3D vector unit, signed fixed point
// Add, subtract, scale, dot, cross, length, normalize, camera-basis rotate
// and absolute value, one word per cycle, saturated results with flags.
// ----------------------------------------------------------------------------
//
//  channel | ports                       | direction | handshake
//  --------+-----------------------------+-----------+---------------------------
//  input   | start, busy, in_data        | in        | taken when start && !busy
//  result  | out_strobe, out_data        | out       | one cycle, no back-pressure
//
// One word enters every cycle; busy stays low. The rotate path is the longest:
// two normalize units in series, each a 33-stage square root followed by a
// FRAC_BITS+1 stage divider. Reset clears the valid line and the result strobe
// only; words in flight are dropped.
// The receiver cannot stall, so nothing in the pipeline ever holds.
//
module vector3_alu import v3alu_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  v3alu_in_t  in_data,
  output logic       out_strobe,
  output v3alu_out_t out_data
);

  localparam int L       = norm_lat(FRAC_BITS);
  localparam int RW      = FRAC_BITS + 2;
  localparam int PW      = 2 * RW + 1;
  localparam int VD      = 2 * L + 4;
  localparam int OUT_LAT = 2 * L + 4;
  localparam int NW      = 3 * RW + 34;

  logic accept;

  // input register and valid line
  v3alu_in_t   in_r;
  logic [VD-1:0] vld_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    in_r <= in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[VD-2:0], accept};
    end
  end

  logic signed [31:0] av  [3];
  logic signed [31:0] bv  [3];
  logic signed [31:0] mop [3];

  assign av[0] = in_r.a_x;
  assign av[1] = in_r.a_y;
  assign av[2] = in_r.a_z;
  assign bv[0] = in_r.b_x;
  assign bv[1] = in_r.b_y;
  assign bv[2] = in_r.b_z;

  // --------------------------------------------------------------------------
  // Short path: one lane per component, products registered, then round,
  // merge the dot product across lanes and saturate.
  // --------------------------------------------------------------------------
  logic signed [63:0] m0_r [3];
  logic signed [63:0] c0_r [3];
  logic signed [63:0] c1_r [3];
  logic signed [32:0] as_r [3];
  logic signed [32:0] abs_r;
  logic [3:0]         f2_r;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;

    assign mop[i] = (in_r.func == FUNC_SCALE) ? in_r.scale : bv[i];

    always_ff @(posedge clk) begin
      m0_r[i] <= av[i] * mop[i];
      c0_r[i] <= av[J] * bv[K];
      c1_r[i] <= av[K] * bv[J];
      if (in_r.func == FUNC_SUB) begin
        as_r[i] <= av[i] - bv[i];
      end else begin
        as_r[i] <= av[i] + bv[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    abs_r <= in_r.scale[31] ? -33'(in_r.scale) : 33'(in_r.scale);
    f2_r  <= in_r.func;
  end

  logic signed [65:0] pre [3];
  logic signed [65:0] pre_s;
  logic [32:0]        sv  [3];
  logic [32:0]        ss;
  v3alu_out_t         simple_nxt;
  v3alu_out_t         simple_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      unique case (f2_r)
        FUNC_ADD, FUNC_SUB: pre[i] = 66'(as_r[i]);
        FUNC_SCALE:         pre[i] = qround(66'(m0_r[i]), FRAC_BITS);
        FUNC_CROSS:         pre[i] = qround(66'(c0_r[i]) - 66'(c1_r[i]), FRAC_BITS);
        default:            pre[i] = '0;
      endcase
      sv[i] = sat32(pre[i]);
    end
    unique case (f2_r)
      FUNC_DOT: pre_s = qround(66'(m0_r[0]) + 66'(m0_r[1]) + 66'(m0_r[2]), FRAC_BITS);
      FUNC_ABS: pre_s = 66'(abs_r);
      default:  pre_s = '0;
    endcase
    ss = sat32(pre_s);

    simple_nxt.r_x         = sv[0][31:0];
    simple_nxt.r_y         = sv[1][31:0];
    simple_nxt.r_z         = sv[2][31:0];
    simple_nxt.r_scalar    = ss[31:0];
    simple_nxt.zero_length = 1'b0;
    simple_nxt.overflow    = sv[0][32] | sv[1][32] | sv[2][32] | ss[32];
  end

  always_ff @(posedge clk) begin
    simple_r <= simple_nxt;
  end

  // --------------------------------------------------------------------------
  // Long path, first normalize: a for length and normalize, b for rotate.
  // --------------------------------------------------------------------------
  logic signed [31:0]   n1_v [3];
  logic signed [RW-1:0] n1_r [3];
  logic                 n1_z;
  logic [32:0]          n1_len;

  for (genvar i = 0; i < 3; i++) begin : g_n1in
    assign n1_v[i] = (in_r.func == FUNC_ROTATE) ? bv[i] : av[i];
  end

  v3alu_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_fwd (
    .clk    (clk),
    .v_i    (n1_v),
    .r_o    (n1_r),
    .zero_o (n1_z),
    .len_o  (n1_len)
  );

  // side = up x f is (f.z, 0, -f.x) exactly; up' = side x f needs products
  logic signed [RW-1:0] sd0_r, sd2_r, sd0b_r, sd2b_r;
  logic signed [PW-1:0] up0p_r, up1p_r, up2p_r;
  logic signed [65:0]   upq [3];
  logic signed [31:0]   up_r [3];

  always_ff @(posedge clk) begin
    sd0_r  <= n1_r[2];
    sd2_r  <= -n1_r[0];
    up0p_r <= n1_r[0] * n1_r[1];
    up1p_r <= n1_r[0] * n1_r[0] + n1_r[2] * n1_r[2];
    up2p_r <= n1_r[2] * n1_r[1];
  end

  always_comb begin
    upq[0] = qround(66'(up0p_r), FRAC_BITS);
    upq[1] = qround(-66'(up1p_r), FRAC_BITS);
    upq[2] = qround(66'(up2p_r), FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    sd0b_r <= sd0_r;
    sd2b_r <= sd2_r;
    for (int i = 0; i < 3; i++) begin
      up_r[i] <= upq[i][31:0];
    end
  end

  // second and third normalize run side by side
  logic signed [31:0]   n2_v [3];
  logic signed [RW-1:0] n2_r [3];
  logic                 n2_z;
  logic signed [RW-1:0] n3_r [3];
  logic                 n3_z;

  assign n2_v[0] = 32'(sd0b_r);
  assign n2_v[1] = 32'sd0;
  assign n2_v[2] = 32'(sd2b_r);

  v3alu_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_side (
    .clk    (clk),
    .v_i    (n2_v),
    .r_o    (n2_r),
    .zero_o (n2_z),
    .len_o  ()
  );

  v3alu_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_up (
    .clk    (clk),
    .v_i    (up_r),
    .r_o    (n3_r),
    .zero_o (n3_z),
    .len_o  ()
  );

  // --------------------------------------------------------------------------
  // Alignment lines
  // --------------------------------------------------------------------------
  logic [NW-1:0] fd;
  logic [95:0]   ad_pk;
  logic [$bits(v3alu_out_t)-1:0] simple_d;
  logic [3:0]    func_d;

  v3alu_delay #(.WIDTH(NW), .DEPTH(L + 2)) u_fwd_dly (
    .clk (clk),
    .d_i ({n1_len, n1_z, n1_r[2], n1_r[1], n1_r[0]}),
    .q_o (fd)
  );

  v3alu_delay #(.WIDTH(96), .DEPTH(2 * L + 2)) u_a_dly (
    .clk (clk),
    .d_i ({in_r.a_z, in_r.a_y, in_r.a_x}),
    .q_o (ad_pk)
  );

  v3alu_delay #(.WIDTH($bits(v3alu_out_t)), .DEPTH(2 * L + 1)) u_simple_dly (
    .clk (clk),
    .d_i (simple_r),
    .q_o (simple_d)
  );

  v3alu_delay #(.WIDTH(4), .DEPTH(2 * L + 3)) u_func_dly (
    .clk (clk),
    .d_i (in_r.func),
    .q_o (func_d)
  );

  logic signed [RW-1:0] fv [3];
  logic signed [31:0]   ad [3];

  for (genvar i = 0; i < 3; i++) begin : g_unpk
    assign fv[i] = fd[RW*i +: RW];
    assign ad[i] = ad_pk[32*i +: 32];
  end

  // map a into the basis: one product per basis vector and component
  logic signed [63:0] rp_r [3][3];
  logic               rz_r;
  logic [NW-1:0]      nh_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      rp_r[i][0] <= n2_r[i] * ad[0];
      rp_r[i][1] <= n3_r[i] * ad[1];
      rp_r[i][2] <= fv[i] * ad[2];
    end
    rz_r <= fd[3*RW] | n2_z | n3_z;
    nh_r <= fd;
  end

  // --------------------------------------------------------------------------
  // Merge: pick the path that the opcode names, finish rotate, saturate.
  // --------------------------------------------------------------------------
  logic signed [65:0]   rsum [3];
  logic [32:0]          rsat [3];
  logic [32:0]          lsat;
  logic signed [RW-1:0] nr   [3];
  v3alu_out_t           out_nxt;
  v3alu_out_t           out_data_r;
  logic                 out_strobe_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rsum[i] = qround(66'(rp_r[i][0]) + 66'(rp_r[i][1]) + 66'(rp_r[i][2]), FRAC_BITS);
      rsat[i] = sat32(rsum[i]);
      nr[i]   = nh_r[RW*i +: RW];
    end
    lsat = sat32($signed(66'(nh_r[NW-1:3*RW+1])));

    out_nxt = '0;
    unique case (func_d)
      FUNC_ADD, FUNC_SUB, FUNC_SCALE, FUNC_DOT, FUNC_CROSS, FUNC_ABS: begin
        out_nxt = v3alu_out_t'(simple_d);
      end
      FUNC_LENGTH: begin
        out_nxt.r_scalar = lsat[31:0];
        out_nxt.overflow = lsat[32];
      end
      FUNC_NORMALIZE: begin
        out_nxt.r_x         = 32'(nr[0]);
        out_nxt.r_y         = 32'(nr[1]);
        out_nxt.r_z         = 32'(nr[2]);
        out_nxt.zero_length = nh_r[3*RW];
      end
      FUNC_ROTATE: begin
        if (rz_r) begin
          out_nxt.zero_length = 1'b1;
        end else begin
          out_nxt.r_x      = rsat[0][31:0];
          out_nxt.r_y      = rsat[1][31:0];
          out_nxt.r_z      = rsat[2][31:0];
          out_nxt.overflow = rsat[0][32] | rsat[1][32] | rsat[2][32];
        end
      end
      default: out_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= vld_r[VD-1];
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

`ifndef ASSERT_OFF
  // every taken word is followed by a result strobe
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##(OUT_LAT + 1) out_strobe)
    else $error("result missing at fixed latency");

  // a zero-length result carries no saturation
  a_zl_no_ov: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.zero_length |-> !out_data.overflow)
    else $error("zero_length with overflow");

  // a zero-length result is all zero
  a_zl_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.zero_length |->
      out_data.r_x == '0 && out_data.r_y == '0 && out_data.r_z == '0 &&
      out_data.r_scalar == '0)
    else $error("zero_length result not zero");
`endif

endmodule

// File: sim/vector3_alu_checker.sv
// ----------------------------------------------------------------------------
// vector3_alu_checker: result predictor and scoreboard for the vector unit
// Watches both channels, computes the expected result word for every accepted
// input word and compares each result word field by field, in order.
// ----------------------------------------------------------------------------
module vector3_alu_checker import v3alu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  v3alu_in_t  in_data,
  input  logic       out_strobe,
  input  v3alu_out_t out_data,
  output int         fail_count,
  output int         pending
);

  localparam int FB = 16;

  v3alu_out_t expected_words[$];

  // Drop FB fraction bits from a sum of exact products, rounding half up.
  function automatic logic signed [95:0] round_q(input logic signed [95:0] v);
    return (v + (96'sd1 <<< (FB - 1))) >>> FB;
  endfunction

  function automatic logic [63:0] root_round(input logic [95:0] n);
    logic [95:0] r;
    logic [95:0] b;
    logic [95:0] x;
    r = 0;
    x = n;
    b = 96'd1 << 94;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (n - r * r > r) r = r + 1;
    return r[63:0];
  endfunction

  function automatic logic [63:0] vec_len(input logic signed [95:0] v[3]);
    logic [95:0] s;
    s = 0;
    for (int i = 0; i < 3; i++) s = s + 96'(v[i] * v[i]);
    return root_round(s);
  endfunction

  // Unit vector; returns 1 on zero length and leaves r at zero.
  function automatic bit unit_vec(input logic signed [95:0] v[3],
                                  output logic signed [95:0] r[3]);
    logic [95:0] l;
    logic [95:0] m;
    logic [95:0] q;
    l = vec_len(v);
    for (int i = 0; i < 3; i++) r[i] = 0;
    if (l == 0) return 1'b1;
    for (int i = 0; i < 3; i++) begin
      m = v[i] < 0 ? -v[i] : v[i];
      q = ((m << FB) + (l >> 1)) / l;
      r[i] = v[i] < 0 ? -$signed(q) : $signed(q);
    end
    return 1'b0;
  endfunction

  function automatic void cross_q(input logic signed [95:0] a[3],
                                  input logic signed [95:0] b[3],
                                  output logic signed [95:0] r[3]);
    r[0] = round_q(a[1] * b[2] - a[2] * b[1]);
    r[1] = round_q(a[2] * b[0] - a[0] * b[2]);
    r[2] = round_q(a[0] * b[1] - a[1] * b[0]);
  endfunction

  function automatic logic [31:0] clamp(input logic signed [95:0] v, ref bit ov);
    if (v > 96'sd2147483647) begin
      ov = 1'b1;
      return 32'h7fff_ffff;
    end
    if (v < -96'sd2147483648) begin
      ov = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic v3alu_out_t predict_word(input v3alu_in_t w);
    logic signed [95:0] a[3];
    logic signed [95:0] b[3];
    logic signed [95:0] r[3];
    logic signed [95:0] f[3];
    logic signed [95:0] side[3];
    logic signed [95:0] up[3];
    logic signed [95:0] s2[3];
    logic signed [95:0] u2[3];
    logic signed [95:0] wup[3];
    logic signed [95:0] sc;
    logic signed [95:0] rs;
    bit ov;
    bit zl;
    v3alu_out_t o;
    a[0] = w.a_x; a[1] = w.a_y; a[2] = w.a_z;
    b[0] = w.b_x; b[1] = w.b_y; b[2] = w.b_z;
    sc = w.scale;
    for (int i = 0; i < 3; i++) r[i] = 0;
    rs = 0;
    ov = 0;
    zl = 0;
    case (w.func)
      FUNC_ADD:       for (int i = 0; i < 3; i++) r[i] = a[i] + b[i];
      FUNC_SUB:       for (int i = 0; i < 3; i++) r[i] = a[i] - b[i];
      FUNC_SCALE:     for (int i = 0; i < 3; i++) r[i] = round_q(a[i] * sc);
      FUNC_DOT:       rs = round_q(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]);
      FUNC_CROSS:     cross_q(a, b, r);
      FUNC_LENGTH:    rs = $signed({32'd0, vec_len(a)});
      FUNC_NORMALIZE: zl = unit_vec(a, r);
      FUNC_ROTATE: begin
        wup[0] = 0; wup[1] = 96'sd1 <<< FB; wup[2] = 0;
        if (unit_vec(b, f)) begin
          zl = 1;
        end else begin
          cross_q(wup, f, side);
          cross_q(side, f, up);
          if (unit_vec(side, s2) || unit_vec(up, u2)) begin
            zl = 1;
          end else begin
            for (int i = 0; i < 3; i++)
              r[i] = round_q(s2[i] * a[0] + u2[i] * a[1] + f[i] * a[2]);
          end
        end
      end
      FUNC_ABS:       rs = sc < 0 ? -sc : sc;
      default: ;
    endcase
    o.r_x = clamp(r[0], ov);
    o.r_y = clamp(r[1], ov);
    o.r_z = clamp(r[2], ov);
    o.r_scalar = clamp(rs, ov);
    o.zero_length = zl;
    o.overflow = ov;
    return o;
  endfunction

  // Sample at the edge; both queue updates happen in one process.
  always @(posedge clk) begin
    v3alu_out_t e;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (out_strobe) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          e = expected_words.pop_front();
          if (out_data !== e) begin
            fail_count <= fail_count + 1;
            if (out_data.r_x !== e.r_x)
              $error("r_x expected %h actual %h", e.r_x, out_data.r_x);
            if (out_data.r_y !== e.r_y)
              $error("r_y expected %h actual %h", e.r_y, out_data.r_y);
            if (out_data.r_z !== e.r_z)
              $error("r_z expected %h actual %h", e.r_z, out_data.r_z);
            if (out_data.r_scalar !== e.r_scalar)
              $error("r_scalar expected %h actual %h", e.r_scalar, out_data.r_scalar);
            if (out_data.zero_length !== e.zero_length)
              $error("zero_length expected %b actual %b", e.zero_length,
                     out_data.zero_length);
            if (out_data.overflow !== e.overflow)
              $error("overflow expected %b actual %b", e.overflow, out_data.overflow);
          end
        end
      end
      if (start && !busy) expected_words.push_back(predict_word(in_data));
    end
    pending <= expected_words.size();
  end

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the 3D vector unit
// Drives directed corner words and then random words with random idle gaps,
// while a checker beside the unit predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb;
  import v3alu_pkg::*;

  localparam int RESULT_LAT = 2 * (16 + 38) + 4;
  localparam int STALL_LIMIT = 4000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  v3alu_in_t  in_data = '0;
  logic       out_strobe;
  v3alu_out_t out_data;
  int         fail_count;
  int         pending;
  int         idle_cycles = 0;

  always #2 clk = ~clk;

  vector3_alu DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_strobe(out_strobe), .out_data(out_data)
  );

  vector3_alu_checker checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  // Watchdog: count cycles with no word taken and no result seen.
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Pick a component value: corners often, else a random 32-bit pattern
  // or a modest Q16.16 value that keeps products in range.
  function automatic logic [31:0] pick_comp();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0;
      3:       return 32'h0001_0000;
      4, 5:    return $urandom();
      default: return 32'($signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000);
    endcase
  endfunction

  // Present one word and hold it until the unit takes it.
  task automatic send_word(input v3alu_in_t w);
    start <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_gaps(input bit gaps);
    if (gaps) begin
      while ($urandom_range(0, 99) < 16) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  function automatic v3alu_in_t make_word(input logic [3:0] f, input logic [31:0] v);
    v3alu_in_t w;
    w.func = f;
    w.a_x = v; w.a_y = v; w.a_z = v;
    w.b_x = v; w.b_y = v; w.b_z = v;
    w.scale = v;
    return w;
  endfunction

  initial begin
    v3alu_in_t w;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every operation at the extremes, zero-length cases, bad opcodes.
    for (int f = 0; f <= 8; f++) begin
      send_word(make_word(4'(f), 32'h7fff_ffff));
      send_word(make_word(4'(f), 32'h8000_0000));
    end
    send_word(make_word(FUNC_NORMALIZE, 32'h0));
    w = make_word(FUNC_ROTATE, 32'h0001_0000);
    w.b_x = 0; w.b_z = 0;               // forward along up: side vector vanishes
    send_word(w);
    send_word(make_word(FUNC_ROTATE, 32'h0));
    send_word(make_word(4'd9, 32'h1234_5678));
    send_word(make_word(4'd15, 32'hffff_ffff));

    // Random: a first stretch of 300 words free of gaps, then random idle gaps
    // before each word that grow while a 16-in-100 draw succeeds.
    for (int n = 0; n < 800; n++) begin
      send_gaps(n >= 300);
      w.func = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                             : 4'($urandom_range(0, 8));
      w.a_x = pick_comp(); w.a_y = pick_comp(); w.a_z = pick_comp();
      w.b_x = pick_comp(); w.b_y = pick_comp(); w.b_z = pick_comp();
      w.scale = pick_comp();
      send_word(w);
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (RESULT_LAT + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/v3alu_pkg.sv
sv/v3alu_delay.sv
sv/v3alu_isqrt.sv
sv/v3alu_div.sv
sv/v3alu_norm.sv
sv/vector3_alu.sv
sim/vector3_alu_checker.sv
sim/tb.sv
